### sv/assert_macros.svh
// Assertion helpers for the filter block.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check an implication in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed in %m");

// Check an implication whose consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed in %m");

`else

`define ASSERT_SAME(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### sv/svf_pkg.sv
package svf_pkg;

  // Block sizing
  localparam int CHANNELS    = 4;
  localparam int OVERSAMPLE  = 3;
  localparam int STORE_DEPTH = 2 * CHANNELS;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int ITER_W      = $clog2(OVERSAMPLE);

  // Fixed-point constants
  localparam logic [16:0] ONE_Q16          = 17'd65536;
  localparam logic [16:0] MIN_CUTOFF_RESET = 17'd27;
  localparam logic [31:0] KX_Q32           = 32'd2231032131;

  // Divisors and their Q0.32 reciprocals
  localparam logic [31:0] DIV_D3    = 32'd6;
  localparam logic [31:0] DIV_D5    = 32'd120;
  localparam logic [31:0] DIV_D7    = 32'd5040;
  localparam logic [31:0] DIV_DOUT  = 32'd3;
  localparam logic [31:0] DIV_M3    = 32'((64'd1 << 32) / 6);
  localparam logic [31:0] DIV_M5    = 32'((64'd1 << 32) / 120);
  localparam logic [31:0] DIV_M7    = 32'((64'd1 << 32) / 5040);
  localparam logic [31:0] DIV_MOUT  = 32'((64'd1 << 32) / 3);

  // Payload words
  typedef struct packed {
    logic [1:0]         channel;
    logic signed [23:0] left_in;
    logic signed [23:0] right_in;
    logic [16:0]        cutoff;
    logic [1:0]         filter_mode;
    logic [16:0]        damping;
  } in_word_t;

  typedef struct packed {
    logic signed [23:0] left_out;
    logic signed [23:0] right_out;
  } out_word_t;

  typedef enum logic [1:0] {
    MODE_OFF = 2'd0,
    MODE_LP  = 2'd1,
    MODE_HP  = 2'd2,
    MODE_BP  = 2'd3
  } mode_t;

  // Multiplier operand selects
  typedef enum logic [3:0] {
    MA_C, MA_X, MA_X2, MA_X3, MA_X5, MA_F, MA_D, MA_DIVV, MA_Q
  } ma_t;

  typedef enum logic [2:0] {
    MB_KX, MB_X, MB_X2, MB_BP, MB_HP, MB_DIVM, MB_DIVD
  } mb_t;

  // Register write-back operations
  typedef enum logic [3:0] {
    WB_NONE, WB_X, WB_X2, WB_X3, WB_X5, WB_X7, WB_Q, WB_DIV, WB_F,
    WB_LOAD, WB_LP, WB_HP, WB_BP, WB_STORE, WB_PASS
  } wb_t;

  // Constant division terms
  typedef enum logic [1:0] {
    DT_X3, DT_X5, DT_X7, DT_OUT
  } dt_t;

  // Jump conditions
  typedef enum logic [1:0] {
    JC_NONE, JC_PASS, JC_ITER, JC_SIDE
  } jc_t;

  typedef enum logic {
    SQ_IDLE, SQ_RUN
  } seq_state_t;

  // Program layout
  localparam int STEP_W = 6;
  localparam logic [STEP_W-1:0] STEP_SIDE = 6'd23;
  localparam logic [STEP_W-1:0] STEP_ITER = 6'd24;
  localparam logic [STEP_W-1:0] STEP_PASS = 6'd35;

  typedef struct packed {
    ma_t               ma;
    mb_t               mb;
    wb_t               wb;
    dt_t               dt;
    jc_t               jc;
    logic [STEP_W-1:0] target;
    logic              done;
  } ucode_t;

  typedef struct packed {
    ucode_t uc;
    logic   side;
  } dp_ctl_t;

  typedef struct packed {
    logic idle;
    logic fire;
  } seq_stat_t;

  localparam ucode_t UC_NOP = '{ma: MA_C, mb: MB_KX, wb: WB_NONE, dt: DT_X3,
                                jc: JC_NONE, target: '0, done: 1'b0};

  function automatic ucode_t uw(input ma_t ma, input mb_t mb, input wb_t wb,
                                input dt_t dt, input jc_t jc,
                                input logic [STEP_W-1:0] target, input logic done);
    ucode_t w;
    w.ma     = ma;
    w.mb     = mb;
    w.wb     = wb;
    w.dt     = dt;
    w.jc     = jc;
    w.target = target;
    w.done   = done;
    return w;
  endfunction

  // Control store: a multiply launched in one step is written back in the next
  function automatic ucode_t ucode(input logic [STEP_W-1:0] a);
    ucode_t w;
    case (a)
      // coefficient: x, its square, then the odd powers; stage the passthrough word as well,
      // the filter path overwrites both results later
      6'd0:  w = uw(MA_C,    MB_KX,   WB_PASS,  DT_X3,  JC_PASS, STEP_PASS, 1'b0);
      6'd1:  w = uw(MA_C,    MB_KX,   WB_X,     DT_X3,  JC_NONE, '0, 1'b0);
      6'd2:  w = uw(MA_X,    MB_X,    WB_NONE,  DT_X3,  JC_NONE, '0, 1'b0);
      6'd3:  w = uw(MA_X,    MB_X,    WB_X2,    DT_X3,  JC_NONE, '0, 1'b0);
      6'd4:  w = uw(MA_X2,   MB_X,    WB_NONE,  DT_X3,  JC_NONE, '0, 1'b0);
      6'd5:  w = uw(MA_X2,   MB_X,    WB_X3,    DT_X3,  JC_NONE, '0, 1'b0);
      6'd6:  w = uw(MA_X3,   MB_X2,   WB_NONE,  DT_X3,  JC_NONE, '0, 1'b0);
      6'd7:  w = uw(MA_X3,   MB_X2,   WB_X5,    DT_X3,  JC_NONE, '0, 1'b0);
      6'd8:  w = uw(MA_X5,   MB_X2,   WB_NONE,  DT_X3,  JC_NONE, '0, 1'b0);
      6'd9:  w = uw(MA_X5,   MB_X2,   WB_X7,    DT_X3,  JC_NONE, '0, 1'b0);
      // x3 / 6
      6'd10: w = uw(MA_DIVV, MB_DIVM, WB_NONE,  DT_X3,  JC_NONE, '0, 1'b0);
      6'd11: w = uw(MA_DIVV, MB_DIVM, WB_Q,     DT_X3,  JC_NONE, '0, 1'b0);
      6'd12: w = uw(MA_Q,    MB_DIVD, WB_NONE,  DT_X3,  JC_NONE, '0, 1'b0);
      6'd13: w = uw(MA_Q,    MB_DIVD, WB_DIV,   DT_X3,  JC_NONE, '0, 1'b0);
      // x5 / 120
      6'd14: w = uw(MA_DIVV, MB_DIVM, WB_NONE,  DT_X5,  JC_NONE, '0, 1'b0);
      6'd15: w = uw(MA_DIVV, MB_DIVM, WB_Q,     DT_X5,  JC_NONE, '0, 1'b0);
      6'd16: w = uw(MA_Q,    MB_DIVD, WB_NONE,  DT_X5,  JC_NONE, '0, 1'b0);
      6'd17: w = uw(MA_Q,    MB_DIVD, WB_DIV,   DT_X5,  JC_NONE, '0, 1'b0);
      // x7 / 5040
      6'd18: w = uw(MA_DIVV, MB_DIVM, WB_NONE,  DT_X7,  JC_NONE, '0, 1'b0);
      6'd19: w = uw(MA_DIVV, MB_DIVM, WB_Q,     DT_X7,  JC_NONE, '0, 1'b0);
      6'd20: w = uw(MA_Q,    MB_DIVD, WB_NONE,  DT_X7,  JC_NONE, '0, 1'b0);
      6'd21: w = uw(MA_Q,    MB_DIVD, WB_DIV,   DT_X7,  JC_NONE, '0, 1'b0);
      6'd22: w = uw(MA_C,    MB_KX,   WB_F,     DT_X3,  JC_NONE, '0, 1'b0);
      // per side: load state, then the oversampled loop
      6'd23: w = uw(MA_C,    MB_KX,   WB_LOAD,  DT_X3,  JC_NONE, '0, 1'b0);
      6'd24: w = uw(MA_F,    MB_BP,   WB_NONE,  DT_X3,  JC_NONE, '0, 1'b0);
      6'd25: w = uw(MA_D,    MB_BP,   WB_LP,    DT_X3,  JC_NONE, '0, 1'b0);
      6'd26: w = uw(MA_D,    MB_BP,   WB_HP,    DT_X3,  JC_NONE, '0, 1'b0);
      6'd27: w = uw(MA_F,    MB_HP,   WB_NONE,  DT_X3,  JC_NONE, '0, 1'b0);
      6'd28: w = uw(MA_F,    MB_HP,   WB_BP,    DT_X3,  JC_ITER, STEP_ITER, 1'b0);
      // store state, then scale the sum by one twelfth
      6'd29: w = uw(MA_C,    MB_KX,   WB_STORE, DT_OUT, JC_NONE, '0, 1'b0);
      6'd30: w = uw(MA_DIVV, MB_DIVM, WB_NONE,  DT_OUT, JC_NONE, '0, 1'b0);
      6'd31: w = uw(MA_DIVV, MB_DIVM, WB_Q,     DT_OUT, JC_NONE, '0, 1'b0);
      6'd32: w = uw(MA_Q,    MB_DIVD, WB_NONE,  DT_OUT, JC_NONE, '0, 1'b0);
      6'd33: w = uw(MA_Q,    MB_DIVD, WB_DIV,   DT_OUT, JC_SIDE, STEP_SIDE, 1'b0);
      6'd34: w = uw(MA_C,    MB_KX,   WB_NONE,  DT_X3,  JC_NONE, '0, 1'b1);
      // passthrough: the word was staged in the first step
      6'd35: w = uw(MA_C,    MB_KX,   WB_NONE,  DT_X3,  JC_NONE, '0, 1'b1);
      default: w = UC_NOP;
    endcase
    return w;
  endfunction

endpackage

### sv/svf_seq.sv
module svf_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                pass,
  input  logic                out_free,
  output svf_pkg::dp_ctl_t    ctl,
  output svf_pkg::seq_stat_t  stat
);
  import svf_pkg::*;

  seq_state_t        state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic [ITER_W-1:0] iter, iter_next;
  logic              side, side_next;
  ucode_t            uc;
  logic              fire;

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SQ_IDLE;
      step  <= '0;
      iter  <= '0;
      side  <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      iter  <= iter_next;
      side  <= side_next;
    end
  end

  // Fetch the control word and pick the next step
  always_comb begin
    state_next = state;
    step_next  = step;
    iter_next  = iter;
    side_next  = side;
    uc         = UC_NOP;
    fire       = 1'b0;
    case (state)
      SQ_IDLE: begin
        if (start) begin
          state_next = SQ_RUN;
          step_next  = '0;
          iter_next  = '0;
          side_next  = 1'b0;
        end
      end
      SQ_RUN: begin
        uc = ucode(step);
        if (uc.done) begin
          // stall on the last step until the output register frees up
          if (out_free) begin
            fire       = 1'b1;
            state_next = SQ_IDLE;
          end
        end else begin
          step_next = STEP_W'(step + 1'b1);
          case (uc.jc)
            JC_PASS: begin
              if (pass) step_next = uc.target;
            end
            JC_ITER: begin
              if (iter == ITER_W'(OVERSAMPLE - 1)) begin
                iter_next = '0;
              end else begin
                iter_next = ITER_W'(iter + 1'b1);
                step_next = uc.target;
              end
            end
            JC_SIDE: begin
              if (!side) begin
                side_next = 1'b1;
                step_next = uc.target;
              end else begin
                side_next = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      default: state_next = SQ_IDLE;
    endcase
  end

  assign ctl.uc    = uc;
  assign ctl.side  = side;
  assign stat.idle = (state == SQ_IDLE);
  assign stat.fire = fire;

endmodule

### sv/svf_datapath.sv
module svf_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  svf_pkg::in_word_t   item,
  input  logic                cfg_we,
  input  logic [16:0]         cfg_data,
  input  svf_pkg::dp_ctl_t    ctl,
  output logic                pass,
  output svf_pkg::out_word_t  result
);
  import svf_pkg::*;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -40'sd2147483648) return 32'sh80000000;
    return $signed(v[31:0]);
  endfunction

  // Configuration and item registers
  logic [16:0]        min_cutoff;
  logic [1:0]         ch;
  mode_t              mode;
  logic signed [23:0] left_s, right_s;
  logic [16:0]        c_q, d_q;
  logic               pass_q;
  logic [16:0]        c_lo, c_cl, d_cl;

  // Coefficient registers
  logic [29:0]        x, x2, x3, x5, x7, q;
  logic signed [31:0] s, f;

  // Filter registers
  logic signed [31:0] lp, bp, hp;
  logic signed [25:0] in_s;
  logic signed [33:0] sum;
  logic [30:0]        u;
  logic               neg;
  logic signed [23:0] res_l, res_r;

  logic signed [31:0] lp_mem [STORE_DEPTH];
  logic signed [31:0] bp_mem [STORE_DEPTH];
  logic [IDX_W-1:0]   idx;

  // Shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic signed [63:0] p;
  logic signed [63:0] p_r30, p_r18, p_r16;

  // Constant division
  logic [30:0]        dvv;
  logic [31:0]        div_m, div_d;
  logic signed [33:0] div_r;
  logic [30:0]        qq;
  logic [31:0]        qn;
  logic signed [23:0] res_val;

  logic signed [31:0] lp_new, hp_new, bp_new;
  logic [33:0]        sum_abs;

  // Clamp cutoff and damping
  always_comb begin
    c_lo = (item.cutoff < min_cutoff) ? min_cutoff : item.cutoff;
    c_cl = (c_lo > ONE_Q16) ? ONE_Q16 : c_lo;
    d_cl = (item.damping > ONE_Q16) ? ONE_Q16 : item.damping;
  end

  assign idx = IDX_W'({ch, ctl.side});

  // Select the division term
  always_comb begin
    case (ctl.uc.dt)
      DT_X3: begin
        dvv = {1'b0, x3};
        div_m = DIV_M3;
        div_d = DIV_D3;
      end
      DT_X5: begin
        dvv = {1'b0, x5};
        div_m = DIV_M5;
        div_d = DIV_D5;
      end
      DT_X7: begin
        dvv = {1'b0, x7};
        div_m = DIV_M7;
        div_d = DIV_D7;
      end
      DT_OUT: begin
        dvv = u;
        div_m = DIV_MOUT;
        div_d = DIV_DOUT;
      end
      default: begin
        dvv = '0;
        div_m = '0;
        div_d = '0;
      end
    endcase
  end

  // Select multiplier operands
  always_comb begin
    case (ctl.uc.ma)
      MA_C:    mul_a = $signed({16'd0, c_q});
      MA_X:    mul_a = $signed({3'd0, x});
      MA_X2:   mul_a = $signed({3'd0, x2});
      MA_X3:   mul_a = $signed({3'd0, x3});
      MA_X5:   mul_a = $signed({3'd0, x5});
      MA_F:    mul_a = 33'(f);
      MA_D:    mul_a = $signed({16'd0, d_q});
      MA_DIVV: mul_a = $signed({2'd0, dvv});
      MA_Q:    mul_a = $signed({3'd0, q});
      default: mul_a = '0;
    endcase
    case (ctl.uc.mb)
      MB_KX:   mul_b = $signed({1'b0, KX_Q32});
      MB_X:    mul_b = $signed({3'd0, x});
      MB_X2:   mul_b = $signed({3'd0, x2});
      MB_BP:   mul_b = 33'(bp);
      MB_HP:   mul_b = 33'(hp);
      MB_DIVM: mul_b = $signed({1'b0, div_m});
      MB_DIVD: mul_b = $signed({1'b0, div_d});
      default: mul_b = '0;
    endcase
  end

  assign prod = mul_a * mul_b;

  // Register the product
  always_ff @(posedge clk) begin
    p <= prod[63:0];
  end

  // Round the product: add one half, then floor
  always_comb begin
    p_r30 = (p + 64'sd536870912) >>> 30;
    p_r18 = (p + 64'sd131072) >>> 18;
    p_r16 = (p + 64'sd32768) >>> 16;
  end

  // Filter updates and division correction
  always_comb begin
    lp_new  = sat32(40'(lp) + 40'(p_r30));
    hp_new  = sat32(40'(in_s) - 40'(lp) - 40'(p_r16));
    bp_new  = sat32(40'(bp) + 40'(p_r30));
    sum_abs = sum[33] ? 34'(-sum) : sum;
    div_r   = $signed({3'd0, dvv}) - $signed(p[33:0]);
    qq      = (div_r >= $signed({2'd0, div_d})) ? ({1'b0, q} + 31'd1) : {1'b0, q};
    qn      = 32'd0 - {1'b0, qq};
    if (!neg) begin
      res_val = (qq > 31'd8388607) ? 24'sh7FFFFF : $signed(qq[23:0]);
    end else begin
      res_val = (qq > 31'd8388608) ? 24'sh800000 : $signed(qn[23:0]);
    end
  end

  // Hold the register and the filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      min_cutoff <= MIN_CUTOFF_RESET;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        lp_mem[i] <= '0;
        bp_mem[i] <= '0;
      end
    end else begin
      if (cfg_we) min_cutoff <= cfg_data;
      if (ctl.uc.wb == WB_STORE) begin
        lp_mem[idx] <= lp;
        bp_mem[idx] <= bp;
      end
    end
  end

  // Capture the item on accept
  always_ff @(posedge clk) begin
    if (load) begin
      ch      <= item.channel;
      mode    <= mode_t'(item.filter_mode);
      left_s  <= item.left_in;
      right_s <= item.right_in;
      c_q     <= c_cl;
      d_q     <= d_cl;
      pass_q  <= (item.filter_mode == MODE_OFF) || (int'(item.channel) >= CHANNELS);
    end
  end

  // Write back results
  always_ff @(posedge clk) begin
    case (ctl.uc.wb)
      WB_X: begin
        x <= p_r18[29:0];
        s <= $signed({2'd0, p_r18[29:0]});
      end
      WB_X2: x2 <= p_r30[29:0];
      WB_X3: x3 <= p_r30[29:0];
      WB_X5: x5 <= p_r30[29:0];
      WB_X7: x7 <= p_r30[29:0];
      WB_Q:  q  <= p[61:32];
      WB_DIV: begin
        case (ctl.uc.dt)
          DT_X3:  s <= s - $signed({1'b0, qq});
          DT_X5:  s <= s + $signed({1'b0, qq});
          DT_X7:  s <= s - $signed({1'b0, qq});
          DT_OUT: begin
            if (ctl.side) res_r <= res_val;
            else          res_l <= res_val;
          end
          default: ;
        endcase
      end
      WB_F: f <= s <<< 1;
      WB_LOAD: begin
        lp   <= lp_mem[idx];
        bp   <= bp_mem[idx];
        in_s <= ctl.side ? $signed({right_s, 2'b00}) : $signed({left_s, 2'b00});
        sum  <= '0;
      end
      WB_LP: begin
        lp <= lp_new;
        if (mode == MODE_LP) sum <= sum + 34'(lp_new);
      end
      WB_HP: begin
        hp <= hp_new;
        if (mode == MODE_HP) sum <= sum + 34'(hp_new);
      end
      WB_BP: begin
        bp <= bp_new;
        if (mode == MODE_BP) sum <= sum + 34'(bp_new);
      end
      WB_STORE: begin
        // magnitude over four; the sign comes back after the divide by three
        u   <= sum_abs[32:2];
        neg <= sum[33];
      end
      WB_PASS: begin
        res_l <= left_s;
        res_r <= right_s;
      end
      default: ;
    endcase
  end

  assign pass             = pass_q;
  assign result.left_out  = res_l;
  assign result.right_out = res_r;

endmodule

### sv/stereo_state_variable_filter_top.sv
// Stereo state-variable filter, microcoded around one shared 33x33 multiplier.
// The program steps through every multiply of the coefficient and both sides' three
// iterations, or only the staged passthrough in off mode; a new word is accepted only
// once the program for the previous word has finished and the sequencer is idle.
// Reset (rst, synchronous, active high) zeroes all filter state and sets min_cutoff to 27.
`include "assert_macros.svh"

module stereo_state_variable_filter_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  svf_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output svf_pkg::out_word_t  out_data,
  input  logic                cfg_we,
  input  logic [16:0]         cfg_data
);
  import svf_pkg::*;

  dp_ctl_t   ctl;
  seq_stat_t stat;
  out_word_t result;
  logic      accept;
  logic      pass;
  logic      out_free;

  assign accept   = in_valid && in_ready;
  assign in_ready = stat.idle;
  assign out_free = !out_valid || out_ready;

  svf_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .pass     (pass),
    .out_free (out_free),
    .ctl      (ctl),
    .stat     (stat)
  );

  svf_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .item     (in_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .ctl      (ctl),
    .pass     (pass),
    .result   (result)
  );

  // Hold the output word until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stat.fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.fire) out_data <= result;
  end

  // A result is only delivered into a free output register
  `ASSERT_SAME(a_fire_free, clk, rst, stat.fire, !out_valid || out_ready)
  // An accepted word starts the program, so the input closes next cycle
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, accept, !in_ready)
  // The output only turns valid right after the program finishes
  `ASSERT_SAME(a_valid_from_fire, clk, rst, $rose(out_valid), $past(stat.fire))

endmodule

### sim/svf_checker.sv
`timescale 1ns / 1ps

module svf_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  svf_pkg::in_word_t   in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  svf_pkg::out_word_t  out_data,
  input  logic                cfg_we,
  input  logic [16:0]         cfg_data,
  output int                  fail_count,
  output int                  outstanding,
  output int                  checked_count
);
  import svf_pkg::*;

  localparam longint S32_MAX = 2147483647;
  localparam longint S32_MIN = -S32_MAX - 1;
  localparam longint S24_MAX = 8388607;
  localparam longint S24_MIN = -8388608;
  localparam int     MAX_REPORTS = 40;

  // Shadow copy of the block's register and filter state
  logic [16:0] cut_floor;
  longint      lp_mem [STORE_DEPTH];
  longint      bp_mem [STORE_DEPTH];

  out_word_t   filtered_q [$];
  out_word_t   want;
  int          errors  = 0;
  int          checked = 0;

  function automatic longint rnd_shr(input longint v, input int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint sat32(input longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  function automatic longint sat24(input longint v);
    if (v > S24_MAX) return S24_MAX;
    if (v < S24_MIN) return S24_MIN;
    return v;
  endfunction

  // 2*sin(x) by a 7th-order series, x = c * 2*pi^2/38, all in Q0.30
  function automatic longint cutoff_coef(input logic [16:0] c);
    longint unsigned x, x2, x3, x5, x7;
    x  = (64'(c) * 64'(KX_Q32) + 64'd131072) >> 18;
    x2 = (x * x + 64'd536870912) >> 30;
    x3 = (x2 * x + 64'd536870912) >> 30;
    x5 = (x3 * x2 + 64'd536870912) >> 30;
    x7 = (x5 * x2 + 64'd536870912) >> 30;
    return 2 * (longint'(x) - longint'(x3 / 6) + longint'(x5 / 120)
                - longint'(x7 / 5040));
  endfunction

  // Run one stereo word through the oversampled filter and update its state
  function automatic out_word_t filter_word(input in_word_t w);
    out_word_t   r;
    logic [16:0] c, d;
    longint      f, xin, lp, bp, hp, acc;
    int          idx;
    mode_t       mode;
    mode = mode_t'(w.filter_mode);
    // off mode and absent voices pass straight through
    if (mode == MODE_OFF || int'(w.channel) >= CHANNELS) begin
      r.left_out  = w.left_in;
      r.right_out = w.right_in;
      return r;
    end
    c = (w.cutoff < cut_floor) ? cut_floor : w.cutoff;
    if (c > ONE_Q16) c = ONE_Q16;
    d = (w.damping > ONE_Q16) ? ONE_Q16 : w.damping;
    f = cutoff_coef(c);
    for (int s = 0; s < 2; s++) begin
      idx = int'(w.channel) * 2 + s;
      xin = (s == 0) ? longint'(w.left_in) : longint'(w.right_in);
      xin = xin * 4;
      lp  = lp_mem[idx];
      bp  = bp_mem[idx];
      acc = 0;
      for (int k = 0; k < OVERSAMPLE; k++) begin
        lp = sat32(lp + rnd_shr(f * bp, 30));
        hp = sat32(xin - lp - rnd_shr(longint'(d) * bp, 16));
        bp = sat32(bp + rnd_shr(f * hp, 30));
        case (mode)
          MODE_LP: acc += lp;
          MODE_HP: acc += hp;
          default: acc += bp;
        endcase
      end
      lp_mem[idx] = lp;
      bp_mem[idx] = bp;
      if (s == 0) r.left_out = 24'(sat24(acc / (OVERSAMPLE * 4)));
      else r.right_out = 24'(sat24(acc / (OVERSAMPLE * 4)));
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int exp_v, input int act_v);
    if (errors < MAX_REPORTS)
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, exp_v, act_v);
    errors++;
  endtask

  // Track the block at every clock edge
  always @(posedge clk) begin
    if (rst) begin
      cut_floor = MIN_CUTOFF_RESET;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        lp_mem[i] = 0;
        bp_mem[i] = 0;
      end
      filtered_q.delete();
    end else begin
      // compare an outgoing word with the oldest prediction
      if (out_valid && out_ready) begin
        if (filtered_q.size() == 0) begin
          flag_mismatch("unexpected word, left_out", 0, out_data.left_out);
        end else begin
          want = filtered_q.pop_front();
          checked++;
          if (out_data.left_out !== want.left_out)
            flag_mismatch("left_out", want.left_out, out_data.left_out);
          if (out_data.right_out !== want.right_out)
            flag_mismatch("right_out", want.right_out, out_data.right_out);
        end
      end
      // predict each accepted word
      if (in_valid && in_ready) filtered_q.push_back(filter_word(in_data));
      // register write takes effect for later words
      if (cfg_we) cut_floor = cfg_data;
    end
    fail_count    <= errors;
    outstanding   <= filtered_q.size();
    checked_count <= checked;
  end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import svf_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 500;
  localparam int SETTLE      = 100;
  localparam logic signed [23:0] S_MIN = 24'sh800000;
  localparam logic signed [23:0] S_MAX = 24'sh7FFFFF;
  localparam logic [16:0] FLOOR_SET [5] = '{17'd0, 17'd65536, 17'h1FFFF, 17'd0, 17'd27};

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_word_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_data;
  logic        cfg_we    = 1'b0;
  logic [16:0] cfg_data  = '0;

  int tx_idle_pct    = 0;
  int rx_idle_pct    = 0;
  int words_in       = 0;
  int words_out      = 0;
  int hold_left      = 0;
  int last_hold_mark = -1;
  int cycles         = 0;
  int fail_count;
  int outstanding;
  int checked_count;

  always #4 clk = ~clk;

  stereo_state_variable_filter_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  svf_checker filter_check (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_we, .cfg_data, .fail_count, .outstanding, .checked_count
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Drive out_ready: random stalls, plus two long hold-offs that back up the block
  always @(posedge clk) begin
    if (out_valid && out_ready) words_out <= words_out + 1;
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if ((words_out == 150 || words_out == 700) && words_out != last_hold_mark) begin
      hold_left      <= HOLD_CYCLES;
      last_hold_mark <= words_out;
      out_ready      <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  function automatic in_word_t make_word(input int ch, input logic signed [23:0] l,
                                         input logic signed [23:0] r, input logic [16:0] cut,
                                         input mode_t m, input logic [16:0] damp);
    in_word_t w;
    w.channel     = 2'(ch);
    w.left_in     = l;
    w.right_in    = r;
    w.cutoff      = cut;
    w.filter_mode = m;
    w.damping     = damp;
    return w;
  endfunction

  function automatic logic signed [23:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return S_MIN;
      1:       return S_MAX;
      2, 3:    return 24'($urandom_range(0, 4095)) - 24'd2048;
      default: return 24'($urandom);
    endcase
  endfunction

  // Mostly audio-range cutoffs, with the clamps and the full field mixed in
  function automatic in_word_t random_word();
    in_word_t w;
    w.channel     = 2'($urandom_range(0, 3));
    w.left_in     = rand_sample();
    w.right_in    = rand_sample();
    w.filter_mode = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0:       w.cutoff = '0;
      1:       w.cutoff = ONE_Q16;
      2:       w.cutoff = 17'($urandom_range(65537, 131071));
      3, 4:    w.cutoff = 17'($urandom);
      default: w.cutoff = 17'($urandom_range(0, 12000));
    endcase
    case ($urandom_range(0, 9))
      0:       w.damping = '0;
      1:       w.damping = ONE_Q16;
      2:       w.damping = 17'($urandom_range(65537, 131071));
      3:       w.damping = 17'($urandom);
      default: w.damping = 17'($urandom_range(2000, 65536));
    endcase
    return w;
  endfunction

  // Offer one word after a random gap; hold it until accepted
  task automatic send_word(input in_word_t w);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_ready !== 1'b1);
    words_in++;
  endtask

  // Drain the block, then write the cutoff floor
  task automatic set_min_cutoff(input logic [16:0] v);
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    tx_idle_pct = 28;
    rx_idle_pct = 66;

    // full-scale and zero words through each mode and clamp
    send_word(make_word(0, S_MIN, S_MAX, 17'd20000, MODE_OFF, 17'd30000));
    send_word(make_word(1, S_MAX, S_MIN, 17'd0, MODE_LP, 17'd0));
    send_word(make_word(1, S_MAX, S_MIN, 17'd0, MODE_LP, ONE_Q16));
    send_word(make_word(2, S_MIN, S_MAX, ONE_Q16, MODE_HP, ONE_Q16));
    send_word(make_word(2, 24'sd0, 24'sd0, 17'h1FFFF, MODE_HP, 17'h1FFFF));
    send_word(make_word(3, S_MAX, S_MAX, 17'd1000, MODE_BP, 17'd100000));
    // off mode must leave voice 1 untouched for the next lowpass word
    send_word(make_word(1, 24'sd12345, -24'sd54321, 17'd500, MODE_OFF, 17'd0));
    send_word(make_word(1, 24'sd0, 24'sd0, 17'd500, MODE_LP, 17'd40000));
    // zero damping at full cutoff: drive voice 3 into saturation
    for (int i = 0; i < 10; i++)
      send_word(make_word(3, (i % 2) ? S_MAX : S_MIN, (i % 2) ? S_MIN : S_MAX,
                          ONE_Q16, MODE_BP, 17'd0));
    for (int i = 0; i < 4; i++)
      send_word(make_word(3, 24'sd0, 24'sd0, ONE_Q16, mode_t'(i), 17'd0));

    repeat (200) send_word(random_word());

    // sweep the cutoff floor, changing the stall pattern as we go
    for (int p = 0; p < 5; p++) begin
      if (p == 1) begin
        tx_idle_pct = 66;
        rx_idle_pct = 28;
      end
      if (p == 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      set_min_cutoff((p == 3) ? 17'($urandom_range(1, 3000)) : FLOOR_SET[p]);
      repeat ((p == 2) ? 150 : 250) send_word(random_word());
    end

    // drain and give the verdict
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d words, checked %0d results over six cutoff floors, all modes, all voices,",
             words_in, checked_count);
    $display("with sender and receiver stalling in turn and two long output hold-offs.");
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
